>>> rtl/core/mpgsa_pkg.sv
package mpgsa_pkg;

  localparam int POS_W   = 12;
  localparam int VAL_W   = 32;
  localparam int SIZE_W  = 13;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic REG_PLANE_SIZE = 1'b0;

  localparam logic [SIZE_W-1:0] PLANE_SIZE_RST = 13'd4096;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                    cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] grad;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    index_error;
    logic                    saturated;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic clr;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_sts_t;

endpackage

>>> rtl/core/mpgsa_regs.sv
module mpgsa_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpgsa_pkg::APB_AW-1:0]   paddr,
  input  logic [mpgsa_pkg::APB_DW-1:0]   pwdata,
  output logic [mpgsa_pkg::APB_DW-1:0]   prdata,
  output logic                           pready,
  output logic [mpgsa_pkg::SIZE_W-1:0]   plane_size
);
  import mpgsa_pkg::*;

  logic wr_en;
  logic sel_size;

  assign pready   = 1'b1;
  assign sel_size = (paddr[2] == REG_PLANE_SIZE);
  assign wr_en    = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_size <= PLANE_SIZE_RST;
    end else if (wr_en && sel_size) begin
      plane_size <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = sel_size ? {{(APB_DW-SIZE_W){1'b0}}, plane_size} : '0;

endmodule

>>> rtl/core/mpgsa_dp.sv
module mpgsa_dp #(
  parameter int MAX_PLANE = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mpgsa_pkg::in_word_t           in_word,
  input  logic [mpgsa_pkg::SIZE_W-1:0]  plane_size,
  input  mpgsa_pkg::dp_cmd_t            cmd,
  output mpgsa_pkg::dp_sts_t            sts,
  output mpgsa_pkg::out_word_t          out_word,
  output logic                          out_strobe
);
  import mpgsa_pkg::*;

  localparam int AW = (MAX_PLANE > 1) ? $clog2(MAX_PLANE) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PLANE - 1);

  logic [VAL_W-1:0]        mem [MAX_PLANE];
  in_word_t                cur;
  logic                    pos_ok;
  logic [AW-1:0]           addr;
  logic [AW-1:0]           clr_cnt;
  logic [VAL_W-1:0]        rdata;
  logic signed [VAL_W:0]   sum;
  logic                    ovf;
  logic signed [VAL_W-1:0] sum_sat;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [VAL_W-1:0]        wdata;

  assign addr = AW'(cur.position);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur    <= in_word;
      pos_ok <= ({1'b0, in_word.position} < plane_size) &&
                (32'(in_word.position) < MAX_PLANE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign sts.clr_last = (clr_cnt == LAST_ADDR);

  assign sum     = {rdata[VAL_W-1], rdata} + {cur.grad[VAL_W-1], cur.grad};
  assign ovf     = sum[VAL_W] ^ sum[VAL_W-1];
  assign sum_sat = ovf ? (sum[VAL_W] ? VAL_MIN : VAL_MAX) : sum[VAL_W-1:0];

  assign we    = cmd.clr | (cmd.exec & pos_ok);
  assign waddr = cmd.clr ? clr_cnt : addr;
  assign wdata = (cmd.clr || cur.cmd == CMD_READ) ? '0 : sum_sat;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_word.index_error <= !pos_ok;
      if (!pos_ok) begin
        out_word.value     <= '0;
        out_word.saturated <= 1'b0;
      end else if (cur.cmd == CMD_READ) begin
        out_word.value     <= rdata;
        out_word.saturated <= 1'b0;
      end else begin
        out_word.value     <= sum_sat;
        out_word.saturated <= ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.exec;
    end
  end

endmodule

>>> rtl/core/mpgsa_ctrl.sv
module mpgsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mpgsa_pkg::dp_sts_t  sts,
  output mpgsa_pkg::dp_cmd_t  cmd
);
  import mpgsa_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EX
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (sts.clr_last) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_RD;
            busy  <= 1'b1;
          end
        end
        S_RD: begin
          state <= S_EX;
        end
        S_EX: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_CLEAR;
          busy  <= 1'b1;
        end
      endcase
    end
  end

  assign cmd.load = start & (state == S_IDLE);
  assign cmd.exec = (state == S_EX);
  assign cmd.clr  = (state == S_CLEAR);

endmodule

>>> rtl/core/max_pool_grad_scatter_add_top.sv
// channel   direction  handshake             word
// item      in         start high, busy low  in_word   (cmd, position, grad)
// result    out        out_strobe, 1 cycle   out_word  (value, index_error, saturated)
// config    in         apb write access      plane_size at byte address 0
//
// an item goes through capture, a registered plane memory read, then
// accumulate/clear write-back with the result registered. after reset a
// clearing pass zeroes MAX_PLANE entries, one a cycle, with busy high. the
// result strobe lasts one cycle; the receiver cannot stall, so there is no
// back-pressure.
module max_pool_grad_scatter_add_top #(
  parameter int MAX_PLANE = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  mpgsa_pkg::in_word_t           in_word,
  output mpgsa_pkg::out_word_t          out_word,
  output logic                          out_strobe,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpgsa_pkg::APB_AW-1:0]  paddr,
  input  logic [mpgsa_pkg::APB_DW-1:0]  pwdata,
  output logic [mpgsa_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import mpgsa_pkg::*;

  logic [SIZE_W-1:0] plane_size;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  mpgsa_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .plane_size (plane_size)
  );

  mpgsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  mpgsa_dp #(
    .MAX_PLANE (MAX_PLANE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_word    (in_word),
    .plane_size (plane_size),
    .cmd        (cmd),
    .sts        (sts),
    .out_word   (out_word),
    .out_strobe (out_strobe)
  );

endmodule
